@@ rtl/tsah_pkg.sv @@
package tsah_pkg;

    localparam int Rounds = 64;

    localparam logic [31:0] RoundK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // "AX:ANCHOR:v1" as big-endian message words
    localparam logic [31:0] TagW0 = 32'h41583A41;
    localparam logic [31:0] TagW1 = 32'h4E43484F;
    localparam logic [31:0] TagW2 = 32'h523A7631;
    localparam logic [31:0] PadWord = 32'h80000000;
    localparam logic [31:0] MsgBits = 32'd416;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [31:0] a, b, c, d, e, f, g, h;
    } hstate_t;

    typedef struct packed {
        logic        func;
        logic [63:0] e0, e1, e2, e3;
    } side_t;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t swap32(word_t v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

@@ rtl/tsah_if.sv @@
interface tsah_in_if (input logic clk);
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] anchor_seq;
    logic [63:0] head_w0, head_w1, head_w2, head_w3;
    logic [63:0] expect_w0, expect_w1, expect_w2, expect_w3;
    modport source (output valid, func, anchor_seq, head_w0, head_w1, head_w2, head_w3,
                    expect_w0, expect_w1, expect_w2, expect_w3, input ready);
    modport sink (input valid, func, anchor_seq, head_w0, head_w1, head_w2, head_w3,
                  expect_w0, expect_w1, expect_w2, expect_w3, output ready);
endinterface

interface tsah_out_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [63:0] digest_w0, digest_w1, digest_w2, digest_w3;
    logic        mismatch;
    modport source (output valid, digest_w0, digest_w1, digest_w2, digest_w3, mismatch,
                    input ready);
    modport sink (input valid, digest_w0, digest_w1, digest_w2, digest_w3, mismatch,
                  output ready);
endinterface

@@ rtl/tagged_sha256_anchor_hash_core.sv @@
// Channel | Dir | Payload
// in_ch   | in  | func, anchor_seq, head_w0..3, expect_w0..3
// out_ch  | out | digest_w0..3, mismatch
// One word enters per cycle unless the output word waits. The line is a load
// stage, 64 round stages and a final add/compare stage. Every stage holds
// whenever the output word waits (global hold); bubbles in the line are not
// squeezed out. Reset clears valid bits only.
module tagged_sha256_anchor_hash_core (
    input logic clk,
    input logic rst_n,
    tsah_in_if.sink    in_ch,
    tsah_out_if.source out_ch
);

    localparam int N = tsah_pkg::Rounds;

    logic              vld [0:N];
    tsah_pkg::hstate_t st  [0:N];
    tsah_pkg::word_t   w   [0:N][0:15];
    tsah_pkg::side_t   sd  [0:N];
    logic              adv;

    logic              ld_vld_reg;
    tsah_pkg::hstate_t ld_st_reg;
    tsah_pkg::word_t   ld_w_reg [0:15];
    tsah_pkg::side_t   ld_sd_reg;

    logic        out_vld_reg;
    logic [63:0] dg_reg [0:3];
    logic        mm_reg;
    logic [31:0] hf [0:7];

    // advance the whole line whenever the output register is free
    assign adv = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // load: build the padded block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_vld_reg <= 1'b0;
        else if (adv)
            ld_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_w_reg[0]  <= tsah_pkg::TagW0;
            ld_w_reg[1]  <= tsah_pkg::TagW1;
            ld_w_reg[2]  <= tsah_pkg::TagW2;
            ld_w_reg[3]  <= tsah_pkg::swap32(in_ch.anchor_seq[31:0]);
            ld_w_reg[4]  <= tsah_pkg::swap32(in_ch.anchor_seq[63:32]);
            ld_w_reg[5]  <= in_ch.head_w0[63:32];
            ld_w_reg[6]  <= in_ch.head_w0[31:0];
            ld_w_reg[7]  <= in_ch.head_w1[63:32];
            ld_w_reg[8]  <= in_ch.head_w1[31:0];
            ld_w_reg[9]  <= in_ch.head_w2[63:32];
            ld_w_reg[10] <= in_ch.head_w2[31:0];
            ld_w_reg[11] <= in_ch.head_w3[63:32];
            ld_w_reg[12] <= in_ch.head_w3[31:0];
            ld_w_reg[13] <= tsah_pkg::PadWord;
            ld_w_reg[14] <= '0;
            ld_w_reg[15] <= tsah_pkg::MsgBits;
            ld_st_reg <= '{a: tsah_pkg::InitH[0], b: tsah_pkg::InitH[1],
                           c: tsah_pkg::InitH[2], d: tsah_pkg::InitH[3],
                           e: tsah_pkg::InitH[4], f: tsah_pkg::InitH[5],
                           g: tsah_pkg::InitH[6], h: tsah_pkg::InitH[7]};
            ld_sd_reg <= '{func: in_ch.func, e0: in_ch.expect_w0, e1: in_ch.expect_w1,
                           e2: in_ch.expect_w2, e3: in_ch.expect_w3};
        end
    end

    assign vld[0] = ld_vld_reg;
    assign st[0]  = ld_st_reg;
    assign w[0]   = ld_w_reg;
    assign sd[0]  = ld_sd_reg;

    // round stages
    for (genvar r = 0; r < N; r++)
    begin : g_rnd
        tsah_round u_rnd (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .idx     (6'(r)),
            .vld_in  (vld[r]),
            .st_in   (st[r]),
            .w_in    (w[r]),
            .sd_in   (sd[r]),
            .vld_out (vld[r+1]),
            .st_out  (st[r+1]),
            .w_out   (w[r+1]),
            .sd_out  (sd[r+1])
        );
    end

    // final add to the initial value
    assign hf[0] = st[N].a + tsah_pkg::InitH[0];
    assign hf[1] = st[N].b + tsah_pkg::InitH[1];
    assign hf[2] = st[N].c + tsah_pkg::InitH[2];
    assign hf[3] = st[N].d + tsah_pkg::InitH[3];
    assign hf[4] = st[N].e + tsah_pkg::InitH[4];
    assign hf[5] = st[N].f + tsah_pkg::InitH[5];
    assign hf[6] = st[N].g + tsah_pkg::InitH[6];
    assign hf[7] = st[N].h + tsah_pkg::InitH[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dg_reg[0] <= {hf[0], hf[1]};
            dg_reg[1] <= {hf[2], hf[3]};
            dg_reg[2] <= {hf[4], hf[5]};
            dg_reg[3] <= {hf[6], hf[7]};
            mm_reg <= sd[N].func && (({hf[0], hf[1]} != sd[N].e0) ||
                      ({hf[2], hf[3]} != sd[N].e1) || ({hf[4], hf[5]} != sd[N].e2) ||
                      ({hf[6], hf[7]} != sd[N].e3));
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.digest_w0 = dg_reg[0];
    assign out_ch.digest_w1 = dg_reg[1];
    assign out_ch.digest_w2 = dg_reg[2];
    assign out_ch.digest_w3 = dg_reg[3];
    assign out_ch.mismatch  = mm_reg;

endmodule

@@ rtl/tsah_round.sv @@
module tsah_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [5:0]          idx,
    input  logic                vld_in,
    input  tsah_pkg::hstate_t   st_in,
    input  tsah_pkg::word_t     w_in [0:15],
    input  tsah_pkg::side_t     sd_in,
    output logic                vld_out,
    output tsah_pkg::hstate_t   st_out,
    output tsah_pkg::word_t     w_out [0:15],
    output tsah_pkg::side_t     sd_out
);

    logic              vld_reg;
    tsah_pkg::hstate_t st_reg, st_next;
    tsah_pkg::word_t   w_reg [0:15];
    tsah_pkg::word_t   w_new;
    tsah_pkg::side_t   sd_reg;

    // one compression round plus one schedule word, window slides by one
    always_comb
    begin
        logic [31:0] s1, ch, t1, s0, mj;
        s1 = tsah_pkg::rotr(st_in.e, 6) ^ tsah_pkg::rotr(st_in.e, 11)
           ^ tsah_pkg::rotr(st_in.e, 25);
        ch = (st_in.e & st_in.f) ^ (~st_in.e & st_in.g);
        t1 = st_in.h + s1 + ch + tsah_pkg::RoundK[idx] + w_in[0];
        s0 = tsah_pkg::rotr(st_in.a, 2) ^ tsah_pkg::rotr(st_in.a, 13)
           ^ tsah_pkg::rotr(st_in.a, 22);
        mj = (st_in.a & st_in.b) ^ (st_in.a & st_in.c) ^ (st_in.b & st_in.c);
        st_next = '{a: t1 + s0 + mj, b: st_in.a, c: st_in.b, d: st_in.c,
                    e: st_in.d + t1, f: st_in.e, g: st_in.f, h: st_in.g};
        w_new = w_in[0] + w_in[9]
              + (tsah_pkg::rotr(w_in[1], 7) ^ tsah_pkg::rotr(w_in[1], 18) ^ (w_in[1] >> 3))
              + (tsah_pkg::rotr(w_in[14], 17) ^ tsah_pkg::rotr(w_in[14], 19)
                 ^ (w_in[14] >> 10));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
            sd_reg <= sd_in;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_in[i+1];
            w_reg[15] <= w_new;
        end
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;
    assign w_out   = w_reg;
    assign sd_out  = sd_reg;

endmodule

@@ rtl/tsah_checker.sv @@
module tsah_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_mismatch
);

    // a waiting output word holds its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // a waiting output word holds its flag
    a_mm_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_mismatch))
        else $error("mismatch changed while stalled");

    // input is taken whenever the output side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a stalled output blocks intake
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("intake while output stalled");

endmodule

bind tagged_sha256_anchor_hash_core tsah_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_mismatch (out_ch.mismatch)
);
